// File: design/tas_pkg.sv
// Shared types and constants of the triangle angle similarity block.
// No dependencies; every other file of the block imports this package.
package tas_pkg;

    // Field widths
    localparam int ANG_W   = 16;   // angles, unsigned Q2.14
    localparam int SCORE_W = 16;   // scores and threshold, unsigned Q1.15
    localparam int VAL_W   = 31;   // pair value, Q.30, at most 1.0
    localparam int NUM_W   = 37;   // 18 * diff^2
    localparam int DEN_W   = 32;   // ref^2
    localparam int DV_W    = 34;   // divisor and partial remainder of the divider
    localparam int Q_W     = 32;   // quotient bits, one divider stage each
    localparam int SUM_W   = 34;   // exponential series sum, Q.32

    // Series lengths
    localparam int EXP_TERMS = 14;
    localparam int SIN_TERMS = 8;
    localparam int SQUARINGS = 5;

    // Arithmetic constants
    localparam logic [VAL_W-1:0]   ONE_Q30     = 31'h4000_0000;
    localparam logic [30:0]        HALF_PI_Q30 = 31'd1686629713;
    localparam logic [SCORE_W-1:0] THR_RESET   = 16'd24576;
    localparam logic [SCORE_W-1:0] SCORE_MAX   = 16'd32768;

    // How a pair value is produced
    typedef enum logic [1:0] {
        KIND_CALC,   // full exponential and sine evaluation
        KIND_ONE,    // equal angles
        KIND_ZERO    // zero reference or exponent out of range
    } t_kind;

    // Sideband that travels with every pipeline stage
    typedef struct packed {
        logic  v;
        t_kind kind;
    } t_side;

    localparam t_side SIDE_IDLE = '{v: 1'b0, kind: KIND_CALC};

    // Result payload
    typedef struct packed {
        logic [SCORE_W-1:0] raw_score;
        logic [SCORE_W-1:0] kept_score;
        logic               is_match;
    } t_res;

endpackage

// File: design/tas_if.sv
// Handshake channels of the triangle angle similarity block: request,
// result and threshold write. Depends on tas_pkg for the field widths.
interface tas_req_if;
    import tas_pkg::*;
    logic             valid;
    logic             ready;
    logic [ANG_W-1:0] ref_angle_0;
    logic [ANG_W-1:0] ref_angle_1;
    logic [ANG_W-1:0] ref_angle_2;
    logic [ANG_W-1:0] cand_angle_0;
    logic [ANG_W-1:0] cand_angle_1;
    logic [ANG_W-1:0] cand_angle_2;
    modport source (output valid, output ref_angle_0, output ref_angle_1, output ref_angle_2,
                    output cand_angle_0, output cand_angle_1, output cand_angle_2,
                    input ready);
    modport sink (input valid, input ref_angle_0, input ref_angle_1, input ref_angle_2,
                  input cand_angle_0, input cand_angle_1, input cand_angle_2,
                  output ready);
endinterface

interface tas_res_if;
    import tas_pkg::*;
    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] raw_score;
    logic [SCORE_W-1:0] kept_score;
    logic               is_match;
    modport source (output valid, output raw_score, output kept_score, output is_match,
                    input ready);
    modport sink (input valid, input raw_score, input kept_score, input is_match,
                  output ready);
endinterface

interface tas_cfg_if;
    import tas_pkg::*;
    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/tas_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on tas_pkg for widths and the sideband type.
module tas_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  tas_pkg::t_side        i_side,
    input  logic [tas_pkg::DV_W-1:0] i_rem,
    input  logic [tas_pkg::Q_W-1:0]  i_low,
    input  logic [tas_pkg::DV_W-1:0] i_dvs,
    output tas_pkg::t_side        o_side,
    output logic [tas_pkg::Q_W-1:0]  o_q
);
    import tas_pkg::*;

    t_side            r_side [0:Q_W-1];
    logic [DV_W-1:0]  r_rem  [0:Q_W-1];
    logic [Q_W-1:0]   r_low  [0:Q_W-1];
    logic [DV_W-1:0]  r_dvs  [0:Q_W-1];
    logic [Q_W-1:0]   r_q    [0:Q_W-1];

    for (genvar j = 0; j < Q_W; j++) begin : g_step
        t_side           s_side;
        logic [DV_W-1:0] s_rem;
        logic [Q_W-1:0]  s_low;
        logic [DV_W-1:0] s_dvs;
        logic [Q_W-1:0]  s_q;
        logic [DV_W:0]   s_trial;
        logic            s_ge;

        if (j == 0) begin : g_head
            assign s_side = i_side;
            assign s_rem  = i_rem;
            assign s_low  = i_low;
            assign s_dvs  = i_dvs;
            assign s_q    = '0;
        end else begin : g_body
            assign s_side = r_side[j-1];
            assign s_rem  = r_rem[j-1];
            assign s_low  = r_low[j-1];
            assign s_dvs  = r_dvs[j-1];
            assign s_q    = r_q[j-1];
        end

        // Bring down the next dividend bit and try the subtract
        assign s_trial = {s_rem, s_low[Q_W-1]};
        assign s_ge    = (s_trial >= {1'b0, s_dvs});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[j] <= SIDE_IDLE;
            end else if (i_en) begin
                r_side[j] <= s_side;
                r_rem[j]  <= s_ge ? DV_W'(s_trial - {1'b0, s_dvs}) : s_trial[DV_W-1:0];
                r_low[j]  <= {s_low[Q_W-2:0], 1'b0};
                r_dvs[j]  <= s_dvs;
                r_q[j]    <= {s_q[Q_W-2:0], s_ge};
            end
        end
    end

    assign o_side = r_side[Q_W-1];
    assign o_q    = r_q[Q_W-1];

endmodule

// File: design/tas_lane.sv
// One angle pair: closeness exp(-18 (D/R)^2) and value sin^3(pi/2 d), Q.30.
// Depends on tas_pkg and instantiates tas_div twice.
module tas_lane (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_v,
    input  logic [tas_pkg::ANG_W-1:0]  i_ref,
    input  logic [tas_pkg::ANG_W-1:0]  i_cand,
    output logic                       o_v,
    output logic [tas_pkg::VAL_W-1:0]  o_val
);
    import tas_pkg::*;

    // ---------------------------------------------------------------- front
    logic [ANG_W-1:0] n_diff;
    t_side            r_f1_side;
    logic [ANG_W-1:0] r_f1_d;
    logic [ANG_W-1:0] r_f1_r;
    t_side            r_f2_side;
    logic [NUM_W-1:0] r_f2_num;
    logic [DEN_W-1:0] r_f2_den;
    t_side            r_f3_side;
    logic [NUM_W-1:0] r_f3_num;
    logic [DEN_W-1:0] r_f3_den;
    logic [DEN_W-1:0] f2_sq;

    assign n_diff = (i_ref > i_cand) ? i_ref - i_cand : i_cand - i_ref;
    assign f2_sq  = DEN_W'(r_f1_d) * DEN_W'(r_f1_d);

    // Classify the pair and take the difference
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_side <= SIDE_IDLE;
        end else if (i_en) begin
            r_f1_side.v <= i_v;
            if (n_diff == '0) begin
                r_f1_side.kind <= KIND_ONE;
            end else if (i_ref == '0) begin
                r_f1_side.kind <= KIND_ZERO;
            end else begin
                r_f1_side.kind <= KIND_CALC;
            end
            r_f1_d <= n_diff;
            r_f1_r <= i_ref;
        end
    end

    // Form 18*D^2 and R^2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_side <= SIDE_IDLE;
        end else if (i_en) begin
            r_f2_side <= r_f1_side;
            r_f2_num  <= (NUM_W'(f2_sq) << 4) + (NUM_W'(f2_sq) << 1);
            r_f2_den  <= DEN_W'(r_f1_r) * DEN_W'(r_f1_r);
        end
    end

    // Drop exponents of 32 and above to a zero value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f3_side <= SIDE_IDLE;
        end else if (i_en) begin
            r_f3_side.v    <= r_f2_side.v;
            r_f3_side.kind <= (r_f2_side.kind == KIND_CALC && r_f2_num >= {r_f2_den, 5'b0})
                            ? KIND_ZERO : r_f2_side.kind;
            r_f3_num <= r_f2_num;
            r_f3_den <= r_f2_den;
        end
    end

    // ------------------------------------------------ g = x/32 in Q0.32
    t_side          g_side;
    logic [Q_W-1:0] g_q;

    tas_div u_div_g (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_side  (r_f3_side),
        .i_rem   (DV_W'(r_f3_num[NUM_W-1:5])),
        .i_low   ({r_f3_num[4:0], 27'b0}),
        .i_dvs   (DV_W'(r_f3_den)),
        .o_side  (g_side),
        .o_q     (g_q)
    );

    // ------------------------------------------------ exp(g) series
    t_side            r_ea_side [1:EXP_TERMS];
    logic [31:0]      r_ea_p    [1:EXP_TERMS];
    logic [31:0]      r_ea_g    [1:EXP_TERMS];
    logic [SUM_W-1:0] r_ea_sum  [1:EXP_TERMS];
    t_side            r_eb_side [1:EXP_TERMS];
    logic [31:0]      r_eb_p    [1:EXP_TERMS];
    logic [31:0]      r_eb_q0   [1:EXP_TERMS];
    logic [31:0]      r_eb_g    [1:EXP_TERMS];
    logic [SUM_W-1:0] r_eb_sum  [1:EXP_TERMS];
    t_side            r_ec_side [1:EXP_TERMS];
    logic [32:0]      r_ec_term [1:EXP_TERMS];
    logic [31:0]      r_ec_g    [1:EXP_TERMS];
    logic [SUM_W-1:0] r_ec_sum  [1:EXP_TERMS];

    for (genvar k = 1; k <= EXP_TERMS; k++) begin : g_exp
        localparam logic [32:0] RCP = 33'((65'd1 << 32) / k);
        t_side            a_side;
        logic [32:0]      a_term;
        logic [31:0]      a_g;
        logic [SUM_W-1:0] a_sum;
        logic [35:0]      c_prod;
        logic [35:0]      c_rem;
        logic [31:0]      c_q;

        if (k == 1) begin : g_head
            assign a_side = g_side;
            assign a_term = 33'h1_0000_0000;
            assign a_g    = g_q;
            assign a_sum  = SUM_W'(33'h1_0000_0000);
        end else begin : g_body
            assign a_side = r_ec_side[k-1];
            assign a_term = r_ec_term[k-1];
            assign a_g    = r_ec_g[k-1];
            assign a_sum  = r_ec_sum[k-1];
        end

        // Correct the reciprocal quotient by at most one
        assign c_prod = 36'(r_eb_q0[k]) * 36'(k);
        assign c_rem  = 36'(r_eb_p[k]) - c_prod;
        assign c_q    = (c_rem >= 36'(k)) ? r_eb_q0[k] + 32'd1 : r_eb_q0[k];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ea_side[k] <= SIDE_IDLE;
                r_eb_side[k] <= SIDE_IDLE;
                r_ec_side[k] <= SIDE_IDLE;
            end else if (i_en) begin
                // term * g
                r_ea_side[k] <= a_side;
                r_ea_p[k]    <= 32'((65'(a_term) * 65'(a_g)) >> 32);
                r_ea_g[k]    <= a_g;
                r_ea_sum[k]  <= a_sum;
                // estimate of the division by k
                r_eb_side[k] <= r_ea_side[k];
                r_eb_p[k]    <= r_ea_p[k];
                r_eb_q0[k]   <= 32'((65'(r_ea_p[k]) * 65'(RCP)) >> 32);
                r_eb_g[k]    <= r_ea_g[k];
                r_eb_sum[k]  <= r_ea_sum[k];
                // exact term, accumulate
                r_ec_side[k] <= r_eb_side[k];
                r_ec_term[k] <= 33'(c_q);
                r_ec_g[k]    <= r_eb_g[k];
                r_ec_sum[k]  <= r_eb_sum[k] + SUM_W'(c_q);
            end
        end
    end

    // ------------------------------------------------ d = 1/exp(g) in Q0.32
    t_side          d_side;
    logic [Q_W-1:0] d_q;

    tas_div u_div_d (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_side  (r_ec_side[EXP_TERMS]),
        .i_rem   (DV_W'(32'hFFFF_FFFF)),
        .i_low   ('1),
        .i_dvs   (r_ec_sum[EXP_TERMS]),
        .o_side  (d_side),
        .o_q     (d_q)
    );

    // ------------------------------------------------ raise to the 32nd power
    t_side       r_sq_side [0:SQUARINGS-1];
    logic [31:0] r_sq_d    [0:SQUARINGS-1];

    for (genvar k = 0; k < SQUARINGS; k++) begin : g_sq
        t_side       q_side;
        logic [31:0] q_d;

        if (k == 0) begin : g_head
            assign q_side = d_side;
            assign q_d    = d_q;
        end else begin : g_body
            assign q_side = r_sq_side[k-1];
            assign q_d    = r_sq_d[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_side[k] <= SIDE_IDLE;
            end else if (i_en) begin
                r_sq_side[k] <= q_side;
                r_sq_d[k]    <= 32'((64'(q_d) * 64'(q_d) + 64'h8000_0000) >> 32);
            end
        end
    end

    // ------------------------------------------------ phi and phi^2
    t_side       r_ph_side;
    logic [30:0] r_ph_phi;
    t_side       r_p2_side;
    logic [30:0] r_p2_phi;
    logic [31:0] r_p2_phi2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph_side <= SIDE_IDLE;
            r_p2_side <= SIDE_IDLE;
        end else if (i_en) begin
            r_ph_side <= r_sq_side[SQUARINGS-1];
            r_ph_phi  <= 31'((63'(r_sq_d[SQUARINGS-1]) * 63'(HALF_PI_Q30)) >> 32);
            r_p2_side <= r_ph_side;
            r_p2_phi  <= r_ph_phi;
            r_p2_phi2 <= 32'((62'(r_ph_phi) * 62'(r_ph_phi)) >> 30);
        end
    end

    // ------------------------------------------------ sin(phi) series
    t_side       r_sa_side [1:SIN_TERMS];
    logic [31:0] r_sa_p    [1:SIN_TERMS];
    logic [31:0] r_sa_phi2 [1:SIN_TERMS];
    logic [32:0] r_sa_pos  [1:SIN_TERMS];
    logic [32:0] r_sa_neg  [1:SIN_TERMS];
    t_side       r_sb_side [1:SIN_TERMS];
    logic [31:0] r_sb_p    [1:SIN_TERMS];
    logic [31:0] r_sb_q0   [1:SIN_TERMS];
    logic [31:0] r_sb_phi2 [1:SIN_TERMS];
    logic [32:0] r_sb_pos  [1:SIN_TERMS];
    logic [32:0] r_sb_neg  [1:SIN_TERMS];
    t_side       r_sc_side [1:SIN_TERMS];
    logic [31:0] r_sc_term [1:SIN_TERMS];
    logic [31:0] r_sc_phi2 [1:SIN_TERMS];
    logic [32:0] r_sc_pos  [1:SIN_TERMS];
    logic [32:0] r_sc_neg  [1:SIN_TERMS];

    for (genvar k = 1; k <= SIN_TERMS; k++) begin : g_sin
        localparam int          DIVR = (2 * k) * (2 * k + 1);
        localparam logic [32:0] RCP  = 33'((65'd1 << 32) / DIVR);
        localparam bit          ODD  = (k % 2) == 1;
        t_side       a_side;
        logic [31:0] a_term;
        logic [31:0] a_phi2;
        logic [32:0] a_pos;
        logic [32:0] a_neg;
        logic [41:0] c_prod;
        logic [41:0] c_rem;
        logic [31:0] c_q;

        if (k == 1) begin : g_head
            assign a_side = r_p2_side;
            assign a_term = 32'(r_p2_phi);
            assign a_phi2 = r_p2_phi2;
            assign a_pos  = 33'(r_p2_phi);
            assign a_neg  = '0;
        end else begin : g_body
            assign a_side = r_sc_side[k-1];
            assign a_term = r_sc_term[k-1];
            assign a_phi2 = r_sc_phi2[k-1];
            assign a_pos  = r_sc_pos[k-1];
            assign a_neg  = r_sc_neg[k-1];
        end

        // Correct the reciprocal quotient by at most one
        assign c_prod = 42'(r_sb_q0[k]) * 42'(DIVR);
        assign c_rem  = 42'(r_sb_p[k]) - c_prod;
        assign c_q    = (c_rem >= 42'(DIVR)) ? r_sb_q0[k] + 32'd1 : r_sb_q0[k];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sa_side[k] <= SIDE_IDLE;
                r_sb_side[k] <= SIDE_IDLE;
                r_sc_side[k] <= SIDE_IDLE;
            end else if (i_en) begin
                // term * phi^2
                r_sa_side[k] <= a_side;
                r_sa_p[k]    <= 32'((64'(a_term) * 64'(a_phi2)) >> 30);
                r_sa_phi2[k] <= a_phi2;
                r_sa_pos[k]  <= a_pos;
                r_sa_neg[k]  <= a_neg;
                // estimate of the division by (2k)(2k+1)
                r_sb_side[k] <= r_sa_side[k];
                r_sb_p[k]    <= r_sa_p[k];
                r_sb_q0[k]   <= 32'((65'(r_sa_p[k]) * 65'(RCP)) >> 32);
                r_sb_phi2[k] <= r_sa_phi2[k];
                r_sb_pos[k]  <= r_sa_pos[k];
                r_sb_neg[k]  <= r_sa_neg[k];
                // exact term, accumulate by sign
                r_sc_side[k] <= r_sb_side[k];
                r_sc_term[k] <= c_q;
                r_sc_phi2[k] <= r_sb_phi2[k];
                r_sc_pos[k]  <= ODD ? r_sb_pos[k] : r_sb_pos[k] + 33'(c_q);
                r_sc_neg[k]  <= ODD ? r_sb_neg[k] + 33'(c_q) : r_sb_neg[k];
            end
        end
    end

    // ------------------------------------------------ clamp and cube
    logic [32:0]      s_diff;
    t_side            r_s_side;
    logic [VAL_W-1:0] r_s_val;
    t_side            r_s2_side;
    logic [VAL_W-1:0] r_s2_s;
    logic [VAL_W-1:0] r_s2_sq;
    t_side            r_cu_side;
    logic [VAL_W-1:0] r_cu_val;
    logic [VAL_W-1:0] cu_val;

    assign s_diff = (r_sc_pos[SIN_TERMS] > r_sc_neg[SIN_TERMS])
                  ? r_sc_pos[SIN_TERMS] - r_sc_neg[SIN_TERMS] : '0;
    assign cu_val = VAL_W'((62'(r_s2_sq) * 62'(r_s2_s)) >> 30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_side  <= SIDE_IDLE;
            r_s2_side <= SIDE_IDLE;
            r_cu_side <= SIDE_IDLE;
        end else if (i_en) begin
            // clamp sine to [0, 1]
            r_s_side <= r_sc_side[SIN_TERMS];
            r_s_val  <= (s_diff > 33'(ONE_Q30)) ? ONE_Q30 : VAL_W'(s_diff);
            // square
            r_s2_side <= r_s_side;
            r_s2_s    <= r_s_val;
            r_s2_sq   <= VAL_W'((62'(r_s_val) * 62'(r_s_val)) >> 30);
            // cube, then apply the special cases
            r_cu_side <= r_s2_side;
            case (r_s2_side.kind)
                KIND_CALC: r_cu_val <= cu_val;
                KIND_ONE:  r_cu_val <= ONE_Q30;
                KIND_ZERO: r_cu_val <= '0;
                default:   r_cu_val <= '0;
            endcase
        end
    end

    assign o_v   = r_cu_side.v;
    assign o_val = r_cu_val;

endmodule

// File: design/triangle_angle_similarity.sv
// Triangle angle similarity scorer: three pair lanes, mean, threshold.
// Depends on tas_pkg, tas_if and tas_lane.
//
// Usage:
//   i_req carries the three reference and three candidate angles (Q2.14).
//   A request is taken at a clock edge with valid and ready both high.
//   o_res returns one result per request, in order: raw_score (Q1.15 mean
//   of the three pair values), kept_score (raw_score, or zero below the
//   threshold) and is_match.
//   i_cfg writes the accept threshold; it is always ready and should only
//   be written while no request is in flight.
//   Throughput: one request per cycle while i_req.ready is high. Each
//   lane's pipeline holds the two 32-stage dividers and the 42-stage
//   exponential and 24-stage sine series.
//   Reset: all pipeline valid bits and the result and skid valid bits
//   clear; the threshold returns to 0.75 (24576).
//   Stall: a held result keeps its value; one more result parks in a skid
//   register, after which i_req.ready drops and the whole pipeline freezes.
module triangle_angle_similarity (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tas_req_if.sink    i_req,
    tas_res_if.source  o_res,
    tas_cfg_if.sink    i_cfg
);
    import tas_pkg::*;

    localparam int          T_W  = 17;
    localparam logic [T_W-1:0] RCP3 = T_W'((1 << 18) / 3);

    logic               en;
    logic               l_v   [0:2];
    logic [VAL_W-1:0]   l_val [0:2];
    logic [SCORE_W-1:0] r_thr;

    logic               r_skid_v;
    logic               r_out_v;
    t_res               r_out;
    t_res               r_skid;
    t_res               p_res;
    logic               n_out_v;
    logic               n_skid_v;
    logic               ld_out_pipe;
    logic               ld_out_skid;
    logic               ld_skid;

    // Advance the whole pipeline while the skid register is empty
    assign en          = !r_skid_v;
    assign i_req.ready = en;

    // ---------------------------------------------------------- lanes
    tas_lane u_lane0 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_v (i_req.valid),
        .i_ref (i_req.ref_angle_0), .i_cand (i_req.cand_angle_0),
        .o_v (l_v[0]), .o_val (l_val[0])
    );

    tas_lane u_lane1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_v (i_req.valid),
        .i_ref (i_req.ref_angle_1), .i_cand (i_req.cand_angle_1),
        .o_v (l_v[1]), .o_val (l_val[1])
    );

    tas_lane u_lane2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_v (i_req.valid),
        .i_ref (i_req.ref_angle_2), .i_cand (i_req.cand_angle_2),
        .o_v (l_v[2]), .o_val (l_val[2])
    );

    // ---------------------------------------------------------- threshold
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg.valid) begin
            r_thr <= i_cfg.data;
        end
    end

    // ---------------------------------------------------------- mean
    logic           r_t1_v;
    logic [T_W-1:0] r_t1_t;
    logic           r_t2_v;
    logic [T_W-1:0] r_t2_t;
    logic [T_W-1:0] r_t2_q0;
    logic           r_t3_v;
    logic [SCORE_W-1:0] r_t3_raw;
    logic [31:0]    t1_total;
    logic [T_W+1:0] t3_rem;
    logic [T_W-1:0] t3_q;

    assign t1_total = 32'(l_val[0]) + 32'(l_val[1]) + 32'(l_val[2]) + 32'd49152;
    assign t3_rem   = (T_W+2)'(r_t2_t) - ((T_W+2)'(r_t2_q0) + ((T_W+2)'(r_t2_q0) << 1));
    assign t3_q     = (t3_rem >= (T_W+2)'(3)) ? r_t2_q0 + T_W'(1) : r_t2_q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_v <= 1'b0;
            r_t2_v <= 1'b0;
            r_t3_v <= 1'b0;
        end else if (en) begin
            // round and drop the 2^15 factor
            r_t1_v  <= l_v[0];
            r_t1_t  <= t1_total[31:15];
            // estimate the division by three
            r_t2_v  <= r_t1_v;
            r_t2_t  <= r_t1_t;
            r_t2_q0 <= T_W'((34'(r_t1_t) * 34'(RCP3)) >> 18);
            // correct and cap
            r_t3_v   <= r_t2_v;
            r_t3_raw <= (t3_q > T_W'(SCORE_MAX)) ? SCORE_MAX : SCORE_W'(t3_q);
        end
    end

    // ---------------------------------------------------------- result
    always_comb begin
        p_res.raw_score  = r_t3_raw;
        p_res.is_match   = (r_t3_raw >= r_thr);
        p_res.kept_score = p_res.is_match ? r_t3_raw : '0;
    end

    // Route the pipeline output to the result register or the skid
    always_comb begin
        n_out_v     = r_out_v;
        n_skid_v    = r_skid_v;
        ld_out_pipe = 1'b0;
        ld_out_skid = 1'b0;
        ld_skid     = 1'b0;
        if (r_skid_v) begin
            if (o_res.ready) begin
                ld_out_skid = 1'b1;
                n_skid_v    = 1'b0;
                n_out_v     = 1'b1;
            end
        end else if (r_t3_v) begin
            if (!r_out_v || o_res.ready) begin
                ld_out_pipe = 1'b1;
                n_out_v     = 1'b1;
            end else begin
                ld_skid  = 1'b1;
                n_skid_v = 1'b1;
            end
        end else if (o_res.ready) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    // Hold payloads unless loaded
    always_ff @(posedge i_clk) begin
        if (ld_out_pipe) begin
            r_out <= p_res;
        end else if (ld_out_skid) begin
            r_out <= r_skid;
        end
        if (ld_skid) begin
            r_skid <= p_res;
        end
    end

    assign o_res.valid      = r_out_v;
    assign o_res.raw_score  = r_out.raw_score;
    assign o_res.kept_score = r_out.kept_score;
    assign o_res.is_match   = r_out.is_match;

    // ---------------------------------------------------------- checks
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (l_v[0] == l_v[1]) && (l_v[0] == l_v[2]))
        else $error("pair lanes out of step");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a result while the result register is empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !o_res.ready))
        else $error("skid filled without a stalled result");

    a_raw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out.raw_score <= SCORE_MAX))
        else $error("raw score above one");

endmodule

// File: dv/tb_top.sv
// Self-checking testbench of triangle_angle_similarity: scores random and corner triangle pairs.
// Depends on tas_pkg, tas_if and the block; holds its own bit-exact score predictor.
module tb_top;
    import tas_pkg::*;

    typedef struct packed {
        logic [ANG_W-1:0] r0, r1, r2, c0, c1, c2;
    } t_pair;

    localparam int LATENCY   = 146;
    localparam int MAX_CYC   = 400000;
    localparam int N_RANDOM  = 730;

    logic i_clk;
    logic i_rst_n;

    tas_req_if req ();
    tas_res_if res ();
    tas_cfg_if cfg ();

    triangle_angle_similarity dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req.sink),
        .o_res   (res.source),
        .i_cfg   (cfg.sink)
    );

    t_pair              pending_q[$];
    t_res               score_q[$];
    logic [SCORE_W-1:0] thr_model;
    int                 err_cnt;
    int                 cyc_cnt;
    int                 accepted_cnt;
    int                 burst_left;
    int                 gap_left;
    int                 hold_left;
    logic               hold_done;
    int                 stall_mode;

    // Clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Score predictor
    // ------------------------------------------------------------------

    // exp(-num/den) in Q0.32
    function automatic longint unsigned neg_exp(longint unsigned num, longint unsigned den);
        longint unsigned whole, rem, g, sum, term, d;
        whole = num / den;
        rem   = num % den;
        g     = (whole << 27) + ((rem << 27) / den);
        sum   = 64'd1 << 32;
        term  = 64'd1 << 32;
        for (int i = 1; i <= EXP_TERMS; i++) begin
            term = ((term * g) >> 32) / longint'(i);
            sum += term;
        end
        d = 64'hFFFF_FFFF_FFFF_FFFF / sum;
        for (int i = 0; i < SQUARINGS; i++)
            d = (d * d + (64'd1 << 31)) >> 32;
        return d;
    endfunction

    // sin^3(pi/2 * d) in Q.30
    function automatic longint unsigned sin_cube(longint unsigned d);
        longint unsigned phi, phi2, term, pos, neg, s;
        phi  = (d * longint'(HALF_PI_Q30)) >> 32;
        phi2 = (phi * phi) >> 30;
        term = phi;
        pos  = phi;
        neg  = 0;
        for (int i = 1; i <= SIN_TERMS; i++) begin
            term = ((term * phi2) >> 30) / longint'((2 * i) * (2 * i + 1));
            if (i % 2 == 1)
                neg += term;
            else
                pos += term;
        end
        s = (pos > neg) ? pos - neg : 0;
        if (s > (64'd1 << 30))
            s = 64'd1 << 30;
        return (((s * s) >> 30) * s) >> 30;
    endfunction

    // Similarity of one angle pair in Q.30
    function automatic longint unsigned angle_sim(logic [ANG_W-1:0] r, logic [ANG_W-1:0] c);
        longint unsigned rv, cv, diff, num, den;
        rv   = r;
        cv   = c;
        diff = (rv > cv) ? rv - cv : cv - rv;
        if (diff == 0)
            return 64'd1 << 30;
        if (rv == 0)
            return 0;
        num = 18 * diff * diff;
        den = rv * rv;
        if (num >= 32 * den)
            return 0;
        return sin_cube(neg_exp(num, den));
    endfunction

    function automatic t_res score_pair(t_pair p, logic [SCORE_W-1:0] thr);
        longint unsigned total, raw;
        t_res            o;
        total = angle_sim(p.r0, p.c0) + angle_sim(p.r1, p.c1) + angle_sim(p.r2, p.c2);
        raw   = (total + 3 * 16384) / (3 * 32768);
        if (raw > 32768)
            raw = 32768;
        o.raw_score  = raw[15:0];
        o.is_match   = (raw >= longint'(thr));
        o.kept_score = o.is_match ? raw[15:0] : '0;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Append one pair to the pending requests
    task automatic add_pending(t_pair p);
        pending_q.insert(pending_q.size(), p);
    endtask

    // One reference/candidate angle of a mostly well-formed pair
    task automatic make_angle(output logic [ANG_W-1:0] r, output logic [ANG_W-1:0] c);
        int rv, cv, span;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                rv   = $urandom_range(1, 51472);
                span = rv / 3 + 1;
                cv   = $urandom_range(0, 1) ? rv + $urandom_range(0, span)
                                            : rv - $urandom_range(0, span);
            end
            4: begin
                rv = $urandom_range(0, 65535);
                cv = rv;
            end
            5: begin
                rv = 0;
                cv = $urandom_range(0, 65535);
            end
            6: begin
                rv = $urandom_range(1, 65535);
                cv = rv + $urandom_range(0, 8) - 4;
            end
            default: begin
                rv = $urandom_range(0, 65535);
                cv = $urandom_range(0, 65535);
            end
        endcase
        if (cv < 0)
            cv = 0;
        if (cv > 65535)
            cv = 65535;
        r = rv[15:0];
        c = cv[15:0];
    endtask

    task automatic push_random(int n);
        t_pair p;
        for (int k = 0; k < n; k++) begin
            make_angle(p.r0, p.c0);
            make_angle(p.r1, p.c1);
            make_angle(p.r2, p.c2);
            add_pending(p);
        end
    endtask

    task automatic push_same(logic [ANG_W-1:0] r, logic [ANG_W-1:0] c);
        add_pending(t_pair'{r0: r, r1: r, r2: r, c0: c, c1: c, c2: c});
    endtask

    // Drain everything in flight, then let the block settle
    task automatic wait_idle();
        while (pending_q.size() != 0 || score_q.size() != 0 || req.valid)
            @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [SCORE_W-1:0] v);
        @(posedge i_clk);
        cfg.valid <= 1'b1;
        cfg.data  <= v;
        @(posedge i_clk);
        while (!cfg.ready)
            @(posedge i_clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic report_mismatch(string what, int got, int want);
        err_cnt++;
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cyc_cnt, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Request driver: bursts with random gaps
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req.valid  <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!(req.valid && !req.ready)) begin
            if (req.valid)
                void'(pending_q.pop_front());
            if (gap_left > 0) begin
                gap_left  <= gap_left - 1;
                req.valid <= 1'b0;
            end else if (pending_q.size() > (req.valid ? 1 : 0) || (!req.valid && pending_q.size() > 0)) begin
                req.valid        <= 1'b1;
                req.ref_angle_0  <= pending_q[0].r0;
                req.ref_angle_1  <= pending_q[0].r1;
                req.ref_angle_2  <= pending_q[0].r2;
                req.cand_angle_0 <= pending_q[0].c0;
                req.cand_angle_1 <= pending_q[0].c1;
                req.cand_angle_2 <= pending_q[0].c2;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                req.valid <= 1'b0;
            end
        end
    end

    // Predict on every accepted request; track threshold writes
    always @(posedge i_clk) begin
        if (i_rst_n && req.valid && req.ready) begin
            score_q.insert(score_q.size(),
                           score_pair({req.ref_angle_0, req.ref_angle_1, req.ref_angle_2,
                                       req.cand_angle_0, req.cand_angle_1,
                                       req.cand_angle_2}, thr_model));
            accepted_cnt++;
        end
        if (!i_rst_n)
            thr_model <= THR_RESET;
        else if (cfg.valid && cfg.ready)
            thr_model <= cfg.data;
    end

    // Long hold-off of the receiver, once, mid-run
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && accepted_cnt >= 500) begin
            hold_left <= 600;
            hold_done <= 1'b1;
        end
    end

    // Receiver stall pattern: one of four randomly drawn modes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready  <= 1'b0;
            stall_mode <= 0;
        end else begin
            if (cyc_cnt % 64 == 0)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0:       res.ready <= (hold_left == 0);
                1:       res.ready <= (hold_left == 0) && $urandom_range(0, 1);
                2:       res.ready <= (hold_left == 0) && ($urandom_range(0, 3) == 0);
                default: res.ready <= (hold_left == 0) && (cyc_cnt % 8 < 5);
            endcase
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && res.valid && res.ready) begin
            if (score_q.size() == 0) begin
                report_mismatch("unexpected result raw_score", res.raw_score, -1);
            end else begin
                want = score_q.pop_front();
                if (res.raw_score !== want.raw_score)
                    report_mismatch("raw_score", res.raw_score, want.raw_score);
                if (res.kept_score !== want.kept_score)
                    report_mismatch("kept_score", res.kept_score, want.kept_score);
                if (res.is_match !== want.is_match)
                    report_mismatch("is_match", res.is_match, want.is_match);
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt > MAX_CYC) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        err_cnt      = 0;
        cyc_cnt      = 0;
        accepted_cnt = 0;
        i_rst_n      = 1'b0;
        cfg.valid    = 1'b0;
        cfg.data     = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners under the reset threshold
        push_same(16'd0, 16'd0);          // both zero: identical
        push_same(16'd0, 16'd1);          // zero reference, different candidate
        push_same(16'd0, 16'hFFFF);
        push_same(16'hFFFF, 16'hFFFF);    // equal, above pi
        push_same(16'hFFFF, 16'd0);
        push_same(16'd51472, 16'd51472);
        push_same(16'd51472, 16'd0);      // full difference: exponent 18, still in range
        push_same(16'd51472, 16'd51471);
        push_same(16'd1, 16'd2);
        push_same(16'd17157, 16'd18157);
        push_same(16'd17157, 16'd14000);
        push_same(16'd6000, 16'd7999);    // exponent just below 2, then exactly 2
        push_same(16'd6000, 16'd8000);
        push_same(16'd60000, 16'd65535);
        push_same(16'd32768, 16'd30000);
        add_pending(t_pair'{r0: 16'd17157, r1: 16'd17157, r2: 16'd17157,
                            c0: 16'd17157, c1: 16'd17157, c2: 16'd20000});
        add_pending(t_pair'{r0: 16'd25736, r1: 16'd12868, r2: 16'd12868,
                            c0: 16'd26000, c1: 16'd0, c2: 16'd12868});
        wait_idle();

        // Threshold settings, extremes among them
        write_threshold(16'd0);
        push_random(120);
        wait_idle();
        write_threshold(SCORE_MAX);
        push_random(120);
        push_same(16'd100, 16'd100);
        wait_idle();
        write_threshold(16'hFFFF);       // nothing can match
        push_random(60);
        push_same(16'd100, 16'd100);
        wait_idle();
        write_threshold(16'd32767);
        push_random(60);
        push_same(16'd100, 16'd100);
        wait_idle();
        write_threshold(16'd1);
        push_random(60);
        wait_idle();
        write_threshold(THR_RESET);
        push_random(N_RANDOM - 420);
        wait_idle();
        write_threshold(16'($urandom_range(0, 65535)));
        push_random(200);
        wait_idle();

        if (err_cnt == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// File: triangle_angle_similarity.f
design/tas_pkg.sv
design/tas_if.sv
design/tas_div.sv
design/tas_lane.sv
design/triangle_angle_similarity.sv
dv/tb_top.sv
